// ===== src/circular_queue_with_reverse_core_assert.svh =====
// Assertion macros shared by the checker of the circular queue core.
`ifndef CIRCULAR_QUEUE_WITH_REVERSE_CORE_ASSERT_SVH
`define CIRCULAR_QUEUE_WITH_REVERSE_CORE_ASSERT_SVH

// Check that cons holds in the same cycle whenever ante holds.
`define CQR_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Check that cons holds in the cycle after ante holds.
`define CQR_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== src/cqr_pkg.sv =====
// Package of the circular queue core: word types, codes and sizes.
package cqr_pkg;

    localparam int CQR_DEPTH_DEF = 8;
    localparam int WORD_W        = 32;
    localparam int OCC_W         = 11;

    localparam logic [1:0] ACT_INSERT  = 2'd0;
    localparam logic [1:0] ACT_REMOVE  = 2'd1;
    localparam logic [1:0] ACT_REVERSE = 2'd2;

    localparam logic [1:0] STAT_DONE  = 2'd0;
    localparam logic [1:0] STAT_FULL  = 2'd1;
    localparam logic [1:0] STAT_EMPTY = 2'd2;

    localparam logic signed [WORD_W-1:0] WORD_NEG_ONE = {WORD_W{1'b1}};

    typedef struct packed {
        logic [1:0]               action;
        logic signed [WORD_W-1:0] in_value;
    } cqr_cmd_t;

    typedef struct packed {
        logic signed [WORD_W-1:0] out_value;
        logic [1:0]               status;
        logic [OCC_W-1:0]         occupancy;
    } cqr_result_t;

endpackage

// ===== src/cqr_slot_add.sv =====
// Shared slot unit: base slot plus offset, wrapped around the queue depth.
module cqr_slot_add
    import cqr_pkg::*;
#(
    parameter int DEPTH = CQR_DEPTH_DEF
)
(
    input  logic [$clog2(DEPTH)-1:0]   base,
    input  logic [$clog2(DEPTH+1)-1:0] offset,
    output logic [$clog2(DEPTH)-1:0]   slot
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam int SUM_W = CNT_W + 1;

    logic [SUM_W-1:0] sum;
    logic [SUM_W-1:0] wrapped;

    // Base is below DEPTH and offset at most DEPTH: one subtract wraps it.
    assign sum     = SUM_W'(base) + SUM_W'(offset);
    assign wrapped = (sum >= SUM_W'(DEPTH)) ? (sum - SUM_W'(DEPTH)) : sum;
    assign slot    = wrapped[IDX_W-1:0];

endmodule

// ===== src/circular_queue_with_reverse_core.sv =====
// Circular queue core: insert, remove and in-place reverse over a word memory.
// Insert, refused remove and no-op give the result strobe from S_EXEC;
//   a remove that returns a word gives it from S_RM_WAIT (registered memory read).
// Reverse swaps floor(n/2) pairs for n held words: one read of both slots, then two writes per swap.
// No new command is taken while busy; start is taken again in the cycle the strobe shows.
// Reset clears head, count and control at once; memory words stay undefined until written.
module circular_queue_with_reverse_core
    import cqr_pkg::*;
#(
    parameter int DEPTH = CQR_DEPTH_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        start,
    output logic        busy,
    input  cqr_cmd_t    cmd,
    output logic        done,
    output cqr_result_t result
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_RM_WAIT,
        S_SW_RD,
        S_SW_WA,
        S_SW_WB
    } state_t;

    state_t                   state_reg;
    logic [1:0]               act_reg;
    logic signed [WORD_W-1:0] val_reg;
    logic [CNT_W-1:0]         count_reg;
    logic [IDX_W-1:0]         head_reg;
    logic [IDX_W-1:0]         lo_reg;
    logic [IDX_W-1:0]         hi_reg;
    logic [CNT_W-1:0]         pairs_reg;
    logic                     done_reg;
    cqr_result_t              result_reg;

    // Word memory with one write port and two registered read ports.
    logic signed [WORD_W-1:0] mem [DEPTH];
    logic signed [WORD_W-1:0] rd_a_reg;
    logic signed [WORD_W-1:0] rd_b_reg;

    logic                     mem_we;
    logic [IDX_W-1:0]         mem_waddr;
    logic signed [WORD_W-1:0] mem_wdata;
    logic                     rd_a_en;
    logic                     rd_b_en;
    logic [IDX_W-1:0]         rd_a_addr;

    logic [CNT_W-1:0]         slot_offset;
    logic [IDX_W-1:0]         slot;
    logic                     full;
    logic                     empty;
    logic [IDX_W-1:0]         lo_next;
    logic [IDX_W-1:0]         hi_next;

    assign full  = (count_reg == CNT_W'(DEPTH));
    assign empty = (count_reg == '0);

    // Pick the offset for the shared slot unit from the pending action:
    // tail slot for insert, next head for remove, last held slot for reverse.
    always_comb
    begin
        case (act_reg)
            ACT_INSERT:  slot_offset = count_reg;
            ACT_REMOVE:  slot_offset = CNT_W'(1);
            ACT_REVERSE: slot_offset = count_reg - CNT_W'(1);
            default:     slot_offset = '0;
        endcase
    end

    cqr_slot_add #(
        .DEPTH (DEPTH)
    ) u_slot (
        .base   (head_reg),
        .offset (slot_offset),
        .slot   (slot)
    );

    // Walk the swap pointers toward each other around the ring.
    assign lo_next = (lo_reg == IDX_W'(DEPTH - 1)) ? '0 : lo_reg + IDX_W'(1);
    assign hi_next = (hi_reg == '0) ? IDX_W'(DEPTH - 1) : hi_reg - IDX_W'(1);

    // Memory port control.
    always_comb
    begin
        mem_we    = 1'b0;
        mem_waddr = slot;
        mem_wdata = val_reg;
        rd_a_en   = 1'b0;
        rd_b_en   = 1'b0;
        rd_a_addr = head_reg;
        case (state_reg)
            S_EXEC:
            begin
                if ((act_reg == ACT_INSERT) && !full)
                begin
                    mem_we = 1'b1;
                end
                if ((act_reg == ACT_REMOVE) && !empty)
                begin
                    rd_a_en = 1'b1;
                end
            end
            S_SW_RD:
            begin
                rd_a_en   = 1'b1;
                rd_b_en   = 1'b1;
                rd_a_addr = lo_reg;
            end
            S_SW_WA:
            begin
                // Low slot takes the word read from the high slot.
                mem_we    = 1'b1;
                mem_waddr = lo_reg;
                mem_wdata = rd_b_reg;
            end
            S_SW_WB:
            begin
                mem_we    = 1'b1;
                mem_waddr = hi_reg;
                mem_wdata = rd_a_reg;
            end
            default:
            begin
                mem_we = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (mem_we)
        begin
            mem[mem_waddr] <= mem_wdata;
        end
        if (rd_a_en)
        begin
            rd_a_reg <= mem[rd_a_addr];
        end
        if (rd_b_en)
        begin
            rd_b_reg <= mem[hi_reg];
        end
    end

    // Sequencer: state, queue pointers and the registered result.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= ACT_INSERT;
            val_reg    <= '0;
            count_reg  <= '0;
            head_reg   <= '0;
            lo_reg     <= '0;
            hi_reg     <= '0;
            pairs_reg  <= '0;
            done_reg   <= 1'b0;
            result_reg <= '0;
        end
        else
        begin
            done_reg <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (start)
                    begin
                        act_reg   <= cmd.action;
                        val_reg   <= cmd.in_value;
                        state_reg <= S_EXEC;
                    end
                end
                S_EXEC:
                begin
                    result_reg.out_value <= '0;
                    result_reg.status    <= STAT_DONE;
                    result_reg.occupancy <= OCC_W'(count_reg);
                    state_reg            <= S_IDLE;
                    case (act_reg)
                        ACT_INSERT:
                        begin
                            done_reg <= 1'b1;
                            if (full)
                            begin
                                result_reg.status <= STAT_FULL;
                            end
                            else
                            begin
                                count_reg            <= count_reg + CNT_W'(1);
                                result_reg.occupancy <= OCC_W'(count_reg + CNT_W'(1));
                            end
                        end
                        ACT_REMOVE:
                        begin
                            if (empty)
                            begin
                                done_reg             <= 1'b1;
                                result_reg.out_value <= WORD_NEG_ONE;
                                result_reg.status    <= STAT_EMPTY;
                            end
                            else
                            begin
                                // Hold the result until the read word lands.
                                count_reg            <= count_reg - CNT_W'(1);
                                head_reg             <= (count_reg == CNT_W'(1)) ? '0 : slot;
                                result_reg.occupancy <= OCC_W'(count_reg - CNT_W'(1));
                                state_reg            <= S_RM_WAIT;
                            end
                        end
                        ACT_REVERSE:
                        begin
                            if (count_reg < CNT_W'(2))
                            begin
                                done_reg <= 1'b1;
                            end
                            else
                            begin
                                lo_reg    <= head_reg;
                                hi_reg    <= slot;
                                pairs_reg <= count_reg >> 1;
                                state_reg <= S_SW_RD;
                            end
                        end
                        default:
                        begin
                            done_reg <= 1'b1;
                        end
                    endcase
                end
                S_RM_WAIT:
                begin
                    done_reg             <= 1'b1;
                    result_reg.out_value <= rd_a_reg;
                    state_reg            <= S_IDLE;
                end
                S_SW_RD:
                begin
                    state_reg <= S_SW_WA;
                end
                S_SW_WA:
                begin
                    state_reg <= S_SW_WB;
                end
                S_SW_WB:
                begin
                    lo_reg    <= lo_next;
                    hi_reg    <= hi_next;
                    pairs_reg <= pairs_reg - CNT_W'(1);
                    if (pairs_reg == CNT_W'(1))
                    begin
                        done_reg  <= 1'b1;
                        state_reg <= S_IDLE;
                    end
                    else
                    begin
                        state_reg <= S_SW_RD;
                    end
                end
                default:
                begin
                    state_reg <= S_IDLE;
                end
            endcase
        end
    end

    assign busy   = (state_reg != S_IDLE);
    assign done   = done_reg;
    assign result = result_reg;

endmodule

// ===== src/cqr_checker.sv =====
// Port checker of the circular queue core and its bind to the top level.
`include "circular_queue_with_reverse_core_assert.svh"

module cqr_checker
    import cqr_pkg::*;
#(
    parameter int DEPTH = CQR_DEPTH_DEF
)
(
    input logic        clk,
    input logic        rst_n,
    input logic        start,
    input logic        busy,
    input logic        done,
    input cqr_result_t result
);

    `CQR_ASSERT_NXT(a_accept_busy, start && !busy, busy)
    `CQR_ASSERT_IMP(a_done_idle, done, !busy)
    `CQR_ASSERT_IMP(a_occ_bound, done, result.occupancy <= OCC_W'(DEPTH))
    `CQR_ASSERT_IMP(a_empty_word, done && (result.status == STAT_EMPTY), (result.out_value == WORD_NEG_ONE) && (result.occupancy == '0))
    `CQR_ASSERT_IMP(a_full_occ, done && (result.status == STAT_FULL), result.occupancy == OCC_W'(DEPTH))

endmodule

bind circular_queue_with_reverse_core cqr_checker #(
    .DEPTH (DEPTH)
) u_cqr_checker (
    .clk    (clk),
    .rst_n  (rst_n),
    .start  (start),
    .busy   (busy),
    .done   (done),
    .result (result)
);

// ===== bench/tb_top.sv =====
// Self-checking testbench for the circular queue core with insert, remove and reverse.
module tb_top;
    import cqr_pkg::*;

    localparam int QDEPTH      = CQR_DEPTH_DEF;
    localparam int RANDOM_WORDS = 1550;
    // Slowest word is a full reverse plus a sender gap; allow a wide margin.
    localparam int CYCLE_LIMIT = 400000;
    localparam int DRAIN_WAIT  = 40;
    localparam int PRINT_CAP   = 100;

    // One pending command word; wait_idle holds it back until every result is in.
    typedef struct packed {
        bit       wait_idle;
        cqr_cmd_t cmd;
    } pending_word_t;

    logic        clk   = 1'b0;
    logic        rst_n = 1'b0;
    logic        start = 1'b0;
    cqr_cmd_t    cmd   = '0;
    logic        busy;
    logic        done;
    cqr_result_t result;

    pending_word_t pending_words[$];
    cqr_result_t   expected_results[$];

    // Predictor's own copy of the queue contents.
    logic signed [WORD_W-1:0] model_store [QDEPTH];
    int                       model_head = 0;
    int                       model_held = 0;

    int mismatch_count = 0;
    int cycle_count    = 0;
    int gap_left       = 0;
    int burst_left     = 0;

    circular_queue_with_reverse_core #(.DEPTH(QDEPTH)) dut (
        .clk    (clk),
        .rst_n  (rst_n),
        .start  (start),
        .busy   (busy),
        .cmd    (cmd),
        .done   (done),
        .result (result)
    );

    always #4 clk = ~clk;

    // Print one line per mismatch (up to a cap) and count every one.
    task automatic report_mismatch(input string what, input cqr_result_t got,
                                   input cqr_result_t want);
        if (mismatch_count < PRINT_CAP)
            $display("mismatch @%0d: %s: got val=%0d st=%0d occ=%0d, want val=%0d st=%0d occ=%0d",
                     cycle_count, what, got.out_value, got.status, got.occupancy,
                     want.out_value, want.status, want.occupancy);
        mismatch_count++;
    endtask

    // Apply one command word to the predicted queue and return the result it must give.
    function automatic cqr_result_t queue_step(input cqr_cmd_t c);
        cqr_result_t              r;
        logic signed [WORD_W-1:0] flipped [QDEPTH];
        int                       i;
        r.out_value = '0;
        r.status    = STAT_DONE;
        case (c.action)
            ACT_INSERT:
                if (model_held == QDEPTH)
                    r.status = STAT_FULL;
                else
                begin
                    if (model_held == 0)
                        model_head = 0;
                    model_store[(model_head + model_held) % QDEPTH] = c.in_value;
                    model_held++;
                end
            ACT_REMOVE:
                if (model_held == 0)
                begin
                    r.out_value = WORD_NEG_ONE;
                    r.status    = STAT_EMPTY;
                end
                else
                begin
                    r.out_value = model_store[model_head];
                    model_held--;
                    // Head snaps back to slot 0 once the queue runs dry.
                    model_head = (model_held == 0) ? 0 : (model_head + 1) % QDEPTH;
                end
            ACT_REVERSE:
                if (model_held != 0)
                begin
                    // Rewrite newest-first starting at slot 0.
                    for (i = 0; i < model_held; i++)
                        flipped[i] = model_store[(model_head + model_held - 1 - i) % QDEPTH];
                    for (i = 0; i < model_held; i++)
                        model_store[i] = flipped[i];
                    model_head = 0;
                end
            default: ;  // unused code: no state change
        endcase
        r.occupancy = OCC_W'(model_held);
        return r;
    endfunction

    // Driver: offer words in bursts with random gaps; predict each word as it is taken.
    always @(posedge clk or negedge rst_n)
    begin : driver
        bit            offer;
        pending_word_t nxt;
        if (!rst_n)
        begin
            start      <= 1'b0;
            cmd        <= '0;
            gap_left   = 0;
            burst_left = 0;
        end
        else if (!start || !busy)
        begin
            offer = 1'b0;
            // Word taken at this edge: advance the prediction now.
            if (start)
                expected_results.push_back(queue_step(cmd));
            if (gap_left != 0)
                gap_left--;
            else if (pending_words.size() != 0 &&
                     !(pending_words[0].wait_idle && expected_results.size() != 0))
            begin
                nxt   = pending_words.pop_front();
                cmd   <= nxt.cmd;
                offer = 1'b1;
                if (burst_left != 0)
                    burst_left--;
                if (burst_left == 0)
                begin
                    // New burst: mostly short, now and then a long unbroken stretch.
                    burst_left = $urandom_range(1, ($urandom_range(0, 3) == 0) ? 80 : 12);
                    gap_left   = $urandom_range(0, 5);
                end
            end
            start <= offer;
        end
    end

    // Monitor: every strobed result must match the oldest prediction.
    always @(posedge clk)
    begin : monitor
        cqr_result_t want;
        if (rst_n && done !== 1'b0)
        begin
            if (expected_results.size() == 0)
                report_mismatch("result with nothing pending", result, '0);
            else
            begin
                want = expected_results.pop_front();
                if (result.out_value !== want.out_value)
                    report_mismatch("out_value", result, want);
                if (result.status !== want.status)
                    report_mismatch("status", result, want);
                if (result.occupancy !== want.occupancy)
                    report_mismatch("occupancy", result, want);
            end
        end
    end

    // Watchdog: drop the run once it passes the cycle limit.
    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_top NOT OK");
            $finish;
        end
    end

    initial
    begin : stimulus
        pending_word_t w;
        int            n;
        int            seg_left;
        int            insert_pct;
        int            pick;

        // Directed: empty-queue cases, unused code, extremes, full queue, wrapped reverse.
        w = '0;
        w.cmd.action = ACT_REMOVE;  w.cmd.in_value = $urandom; pending_words.push_back(w);
        w.cmd.action = ACT_REVERSE; w.cmd.in_value = $urandom; pending_words.push_back(w);
        w.cmd.action = 2'd3;        w.cmd.in_value = $urandom; pending_words.push_back(w);
        w.cmd.action = ACT_INSERT;
        w.cmd.in_value = 32'sh7FFF_FFFF; pending_words.push_back(w);
        w.cmd.in_value = 32'sh8000_0000; pending_words.push_back(w);
        w.cmd.in_value = 32'sh0000_0000; pending_words.push_back(w);
        w.cmd.in_value = WORD_NEG_ONE;   pending_words.push_back(w);
        w.cmd.in_value = 32'sh0000_0001; pending_words.push_back(w);
        w.cmd.in_value = 32'shAAAA_5555; pending_words.push_back(w);
        w.cmd.in_value = 32'sh5555_AAAA; pending_words.push_back(w);
        w.cmd.in_value = 32'sh1234_5678; pending_words.push_back(w);
        // Insert into a full queue: refused and dropped.
        w.cmd.in_value = 32'sh0BAD_0BAD; pending_words.push_back(w);
        w.cmd.action = ACT_REVERSE; pending_words.push_back(w);
        w.cmd.action = ACT_REMOVE;
        repeat (3) pending_words.push_back(w);
        // Tail wraps past the last slot.
        w.cmd.action = ACT_INSERT; w.cmd.in_value = 32'sh7654_3210; pending_words.push_back(w);
        w.cmd.action = ACT_REVERSE; pending_words.push_back(w);
        w.cmd.action = ACT_REMOVE;  pending_words.push_back(w);
        w.cmd.action = 2'd3; w.cmd.in_value = $urandom; pending_words.push_back(w);
        // Odd count with head off slot 0.
        w.cmd.action = ACT_REVERSE; pending_words.push_back(w);
        w.cmd.action = ACT_REMOVE;  pending_words.push_back(w);

        // Random: segments that lean toward filling, draining or neither,
        // so the queue keeps hitting full and empty.
        seg_left   = 0;
        insert_pct = 45;
        for (n = 0; n < RANDOM_WORDS; n++)
        begin
            if (seg_left == 0)
            begin
                case ($urandom_range(0, 2))
                    0:       insert_pct = 70;
                    1:       insert_pct = 20;
                    default: insert_pct = 45;
                endcase
                seg_left = $urandom_range(8, 40);
            end
            seg_left--;
            w = '0;
            // Hold the sender until the block has emptied its result pipe.
            w.wait_idle = (n % 400 == 0);
            pick = $urandom_range(0, 99);
            if (pick >= 97)
                w.cmd.action = 2'd3;
            else if (pick >= 85)
                w.cmd.action = ACT_REVERSE;
            else if (pick < insert_pct)
                w.cmd.action = ACT_INSERT;
            else
                w.cmd.action = ACT_REMOVE;
            case ($urandom_range(0, 7))
                0:       w.cmd.in_value = 32'sh7FFF_FFFF;
                1:       w.cmd.in_value = 32'sh8000_0000;
                2:       w.cmd.in_value = ($urandom_range(0, 1) == 0) ? WORD_NEG_ONE : '0;
                default: w.cmd.in_value = $urandom;
            endcase
            pending_words.push_back(w);
        end

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;

        // Let the sender run dry, then wait out every result and the tail latency.
        while (pending_words.size() != 0 || start)
            @(posedge clk);
        while (expected_results.size() != 0)
            @(posedge clk);
        repeat (DRAIN_WAIT) @(posedge clk);

        if (mismatch_count == 0 && expected_results.size() == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

endmodule
